[design/spr_pkg.sv]
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants of the serial packet receiver
// Opcodes, event codes, framing phases, payload structs and the memory
// request bundle passed from the framing control to the payload store.
// ----------------------------------------------------------------------------
package spr_pkg;

  // Payload buffer depth and derived widths.
  localparam int unsigned BufferDepth = 256;
  localparam int unsigned AddrW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int unsigned PtrW = $clog2(BufferDepth + 1);

  localparam logic [15:0] TimeoutReset = 16'd4000;
  localparam logic [15:0] TickMax = 16'hFFFF;
  localparam logic [7:0] LengthBias = 8'd3;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_DISCARD = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_HEADER   = 3'd1,
    EV_OK       = 3'd2,
    EV_CSUM_BAD = 3'd3,
    EV_TIMEOUT  = 3'd4,
    EV_OVERFLOW = 3'd5,
    EV_DROPPED  = 3'd6
  } ev_e;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_LEN  = 3'd1,
    PH_ADDR = 3'd2,
    PH_TYPE = 3'd3,
    PH_DATA = 3'd4,
    PH_CSUM = 3'd5,
    PH_HELD = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CFG_HEADER  = 2'd0,
    CFG_TIMEOUT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } spr_in_t;

  typedef struct packed {
    logic       packet_ready;
    logic [7:0] packet_type;
    logic [7:0] packet_address;
    logic [7:0] payload_length;
    logic [7:0] read_data;
    logic [2:0] event_res;
  } spr_out_t;

  // Result fields known at the end of the control cycle, before the
  // store's read data returns.
  typedef struct packed {
    logic       packet_ready;
    logic [7:0] packet_type;
    logic [7:0] packet_address;
    logic [7:0] payload_length;
    logic [2:0] event_res;
    logic       rd_en;
  } spr_stat_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } spr_mem_req_t;

endpackage

[design/spr_store.sv]
// ----------------------------------------------------------------------------
// spr_store: payload buffer
// Single write port, single registered read port. The read data holds
// until the next read.
// ----------------------------------------------------------------------------
module spr_store import spr_pkg::*; (
  input  logic         clk_i,
  input  spr_mem_req_t req_i,
  output logic [7:0]   rdata_o
);

  logic [7:0] mem_q [BufferDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/spr_ctrl.sv]
// ----------------------------------------------------------------------------
// spr_ctrl: framing control
// Walks the frame phases, keeps the running checksum, the header fields,
// the write pointer and the tick timeout, and issues store accesses.
// ----------------------------------------------------------------------------
module spr_ctrl import spr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  spr_in_t      item_i,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  output spr_stat_t    stat_o,
  output spr_mem_req_t mem_req_o
);

  phase_e          phase_q, phase_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      addr_q, addr_d;
  logic [7:0]      type_q, type_d;
  logic [PtrW-1:0] wp_q, wp_d;
  logic [15:0]     tcount_q, tcount_d;
  logic            armed_q, armed_d;
  logic [7:0]      header_q;
  logic [15:0]     timeout_q;

  logic [15:0] limit;
  logic        add_byte;
  ev_e         ev;
  logic [7:0]  b;

  assign b = item_i.data_byte;
  assign limit = (timeout_q != 16'd0) ? timeout_q : 16'd1;

  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    len_d     = len_q;
    addr_d    = addr_q;
    type_d    = type_q;
    wp_d      = wp_q;
    tcount_d  = tcount_q;
    armed_d   = armed_q;
    add_byte  = 1'b0;
    ev        = EV_NONE;
    mem_req_o = '0;
    mem_req_o.wdata = b;
    mem_req_o.raddr = AddrW'(item_i.read_index);

    if (accept_i) begin
      case (op_e'(item_i.opcode))
        OP_BYTE: begin
          add_byte = 1'b1;
          case (phase_q)
            PH_HELD: begin
              phase_d  = PH_WAIT;
              add_byte = 1'b0;
              ev       = EV_DROPPED;
            end
            PH_LEN: begin
              len_d   = b - LengthBias;
              phase_d = PH_ADDR;
            end
            PH_ADDR: begin
              addr_d  = b;
              phase_d = PH_TYPE;
            end
            PH_TYPE: begin
              type_d  = b;
              wp_d    = '0;
              phase_d = (len_q != 8'd0) ? PH_DATA : PH_CSUM;
            end
            PH_DATA: begin
              if (32'(wp_q) >= BufferDepth) begin
                phase_d  = PH_WAIT;
                armed_d  = 1'b0;
                add_byte = 1'b0;
                ev       = EV_OVERFLOW;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = AddrW'(wp_q);
                wp_d = PtrW'(wp_q + 1'b1);
                if (32'(wp_d) >= 32'(len_q)) begin
                  phase_d = PH_CSUM;
                end
              end
            end
            PH_CSUM: begin
              armed_d  = 1'b0;
              add_byte = 1'b0;
              if (b != sum_q) begin
                phase_d = PH_WAIT;
                ev      = EV_CSUM_BAD;
              end else begin
                if (32'(wp_q) < BufferDepth) begin
                  mem_req_o.we    = 1'b1;
                  mem_req_o.waddr = AddrW'(wp_q);
                end
                phase_d = PH_HELD;
                ev      = EV_OK;
              end
            end
            default: begin
              phase_d = PH_WAIT;
              if (b != header_q) begin
                add_byte = 1'b0;
              end else begin
                phase_d  = PH_LEN;
                sum_d    = 8'd0;
                tcount_d = 16'd0;
                armed_d  = 1'b1;
                ev       = EV_HEADER;
              end
            end
          endcase
        end
        OP_TICK: begin
          if (armed_q) begin
            if (tcount_q != TickMax) begin
              tcount_d = tcount_q + 16'd1;
            end
            if (tcount_d >= limit) begin
              armed_d = 1'b0;
              phase_d = PH_WAIT;
              ev      = EV_TIMEOUT;
            end
          end
        end
        OP_DISCARD: begin
          phase_d = PH_WAIT;
          armed_d = 1'b0;
        end
        default: begin
          mem_req_o.re = (32'(item_i.read_index) < BufferDepth);
        end
      endcase
      if (add_byte) begin
        sum_d = sum_d + b;
      end
    end
  end

  assign stat_o.packet_ready   = (phase_d == PH_HELD);
  assign stat_o.packet_type    = type_d;
  assign stat_o.packet_address = addr_d;
  assign stat_o.payload_length = len_d;
  assign stat_o.event_res      = ev;
  assign stat_o.rd_en          = mem_req_o.re;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      sum_q     <= '0;
      len_q     <= '0;
      addr_q    <= '0;
      type_q    <= '0;
      wp_q      <= '0;
      tcount_q  <= '0;
      armed_q   <= 1'b0;
      header_q  <= '0;
      timeout_q <= TimeoutReset;
    end else begin
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      len_q    <= len_d;
      addr_q   <= addr_d;
      type_q   <= type_d;
      wp_q     <= wp_d;
      tcount_q <= tcount_d;
      armed_q  <= armed_d;
      if (cfg_we_i && cfg_index_i == CFG_HEADER) begin
        header_q <= cfg_data_i[7:0];
      end
      if (cfg_we_i && cfg_index_i == CFG_TIMEOUT) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // A held packet never has a running timeout.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HELD |-> !armed_q)
    else $error("timeout armed while a packet is held");

  // A store write only happens on an accepted byte in the data or checksum phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> accept_i && (phase_q == PH_DATA || phase_q == PH_CSUM))
    else $error("store written outside the payload phases");

  // The pointer never runs past the end of the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_q) <= BufferDepth)
    else $error("write pointer beyond buffer depth");

endmodule

[design/serial_packet_receiver_top.sv]
// ----------------------------------------------------------------------------
// serial_packet_receiver_top: serial frame deframer with additive checksum
// Each result passes stage one and the output register before it is presented.
// Throughput: one item per cycle unless output back-pressure fills both stages;
// the framing control updates in the accepting cycle, the store read is registered.
// Reset clears all control state and restores the configuration defaults;
// the payload store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module serial_packet_receiver_top import spr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  spr_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output spr_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Pipeline: the control updates its registers at the input transfer and
  // launches any store access in the same cycle. Stage one holds the status
  // fields while the store read completes; stage two is the output register
  // that merges the read data. Stage one drains whenever stage two is empty
  // or being taken, so new input waits only while both stages are full and stalled.

  logic         accept;
  logic         adv1;
  spr_stat_t    stat;
  spr_mem_req_t mem_req;
  logic [7:0]   rdata;

  logic         v1_q;
  spr_stat_t    s1_q;
  logic         v2_q;
  spr_out_t     out_q;

  // Configuration writes are always taken; the user must send them only while idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  assign adv1       = !v2_q || out_ready_i;
  assign in_ready_o = !v1_q || adv1;
  assign accept     = in_valid_i && in_ready_o;

  spr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat),
    .mem_req_o   (mem_req)
  );

  spr_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Stage one and stage two valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (adv1) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= stat;
    end
    // The store holds its read data until the next read, and a new read
    // only launches when stage one moves on at the same edge.
    if (adv1 && v1_q) begin
      out_q.packet_ready   <= s1_q.packet_ready;
      out_q.packet_type    <= s1_q.packet_type;
      out_q.packet_address <= s1_q.packet_address;
      out_q.payload_length <= s1_q.payload_length;
      out_q.read_data      <= s1_q.rd_en ? rdata : 8'd0;
      out_q.event_res      <= s1_q.event_res;
    end
  end

  assign out_valid_o = v2_q;
  assign out_data_o  = out_q;

  // An input transfer always lands in stage one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted item lost before stage one");

  // A stalled stage one keeps its status fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !adv1 |=> v1_q && $stable(s1_q))
    else $error("stage one changed while stalled");

  // The control never reads and writes the store in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("store read and write in one cycle");

  // A store access only comes with an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we || mem_req.re) |-> accept)
    else $error("store access without an input transfer");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the serial packet receiver
// Streams received bytes, timer ticks, discards and buffer reads into the
// block. A behavioral deframer predicts every status word. A short table of
// directed steps comes first, then randomized frames under four pacing modes.
// ----------------------------------------------------------------------------
module tb_top;
  import spr_pkg::*;

  localparam int QuietLimit = 2000;

  // Pins an expected event and ready flag onto one table row.
  typedef struct packed {
    bit   typed;
    ev_e  ev;
    bit   ready;
  } pinned_t;

  typedef struct packed {
    bit          is_cfg;
    cfg_idx_e    reg_idx;
    logic [15:0] reg_val;
    op_e         op;
    logic [7:0]  data;
    logic [7:0]  idx;
    pinned_t     pin;
  } stim_row_t;

  localparam pinned_t NoPin = '{1'b0, EV_NONE, 1'b0};

  // Directed steps. Rows with a pinned event are easy to read off by hand;
  // every other field and row is left to the deframer prediction.
  stim_row_t directed_steps [30] = '{
    // Default header 0x00: a stray byte and an unarmed tick do nothing.
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h5A, 8'h00, '{1'b1, EV_NONE,     1'b0}},
    '{1'b0, CFG_HEADER,  16'h0000, OP_TICK,    8'h00, 8'h00, '{1'b1, EV_NONE,     1'b0}},
    // Good frame with two payload bytes at both extremes.
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h00, 8'h00, '{1'b1, EV_HEADER,   1'b0}},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h05, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'hFF, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h80, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'hFF, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h00, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h83, 8'h00, '{1'b1, EV_OK,       1'b1}},
    '{1'b0, CFG_HEADER,  16'h0000, OP_READ,    8'h00, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_READ,    8'h00, 8'h02, NoPin},
    // A byte on a held packet drops it, even when it looks like a header.
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h00, 8'h00, '{1'b1, EV_DROPPED,  1'b0}},
    // Zero-length payload followed by a wrong checksum.
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h00, 8'h00, '{1'b1, EV_HEADER,   1'b0}},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h03, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h12, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h34, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h00, 8'h00, '{1'b1, EV_CSUM_BAD, 1'b0}},
    // A zero timeout acts as one tick.
    '{1'b1, CFG_TIMEOUT, 16'h0000, OP_BYTE,    8'h00, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h00, 8'h00, '{1'b1, EV_HEADER,   1'b0}},
    '{1'b0, CFG_HEADER,  16'h0000, OP_TICK,    8'h00, 8'h00, '{1'b1, EV_TIMEOUT,  1'b0}},
    // Top header and timeout values; a length byte of 2 wraps to 255,
    // then a discard in the middle of the frame.
    '{1'b1, CFG_HEADER,  16'h00FF, OP_BYTE,    8'h00, 8'h00, NoPin},
    '{1'b1, CFG_TIMEOUT, 16'hFFFF, OP_BYTE,    8'h00, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'hFF, 8'h00, '{1'b1, EV_HEADER,   1'b0}},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h02, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_DISCARD, 8'h00, 8'h00, '{1'b1, EV_NONE,     1'b0}},
    // Empty frame with a good checksum.
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'hFF, 8'h00, '{1'b1, EV_HEADER,   1'b0}},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h03, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h00, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h00, 8'h00, NoPin},
    '{1'b0, CFG_HEADER,  16'h0000, OP_BYTE,    8'h02, 8'h00, '{1'b1, EV_OK,       1'b1}}
  };

  // Pacing of the four random phases, in percent of cycles.
  int src_pct_tbl [4]  = '{0, 47, 0, 24};
  int sink_pct_tbl [4] = '{0, 0, 47, 24};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  spr_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  spr_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_HEADER;
  logic [15:0] cfg_data = '0;

  // Deframer state as the bench believes it to be.
  logic [7:0]  hdr_cfg = 8'h00;
  logic [15:0] timeout_cfg = TimeoutReset;
  phase_e      rx_phase = PH_WAIT;
  logic [7:0]  frame_sum = '0;
  logic [7:0]  len_q = '0;
  logic [7:0]  addr_q = '0;
  logic [7:0]  type_q = '0;
  int          fill_ptr = 0;
  logic [7:0]  payload_mem [BufferDepth];
  logic [15:0] tick_count = '0;
  bit          tick_armed = 1'b0;
  // Entries below this index have been written; reads stay under it.
  int          mem_fill = 0;

  spr_out_t    pending_status_q [$];
  pinned_t     pinned_q [$];

  int n_sent = 0;
  int n_accepted = 0;
  int n_matched = 0;
  int n_errors = 0;
  int n_directed = 0;
  int n_cfg_writes = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int ev_seen [8] = '{default: 0};

  always #5 clk_i = ~clk_i;

  serial_packet_receiver_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Advances the deframer by one input item and returns the status word
  // that the block should report for it.
  function automatic spr_out_t deframe_step(spr_in_t it);
    spr_out_t    r;
    ev_e         ev;
    logic [7:0]  b;
    logic [15:0] lim;
    bit          add_sum;
    r = '0;
    ev = EV_NONE;
    b = it.data_byte;
    case (it.opcode)
      OP_BYTE: begin
        add_sum = 1'b1;
        case (rx_phase)
          PH_HELD: begin
            // The byte only knocks the held packet out; it is not examined.
            rx_phase = PH_WAIT;
            ev = EV_DROPPED;
            add_sum = 1'b0;
          end
          PH_LEN: begin
            len_q = b - LengthBias;
            rx_phase = PH_ADDR;
          end
          PH_ADDR: begin
            addr_q = b;
            rx_phase = PH_TYPE;
          end
          PH_TYPE: begin
            type_q = b;
            fill_ptr = 0;
            rx_phase = (len_q != 8'd0) ? PH_DATA : PH_CSUM;
          end
          PH_DATA: begin
            if (fill_ptr >= BufferDepth) begin
              rx_phase = PH_WAIT;
              tick_armed = 1'b0;
              ev = EV_OVERFLOW;
              add_sum = 1'b0;
            end else begin
              payload_mem[fill_ptr] = b;
              fill_ptr++;
              if (fill_ptr > mem_fill) mem_fill = fill_ptr;
              if (fill_ptr >= len_q) rx_phase = PH_CSUM;
            end
          end
          PH_CSUM: begin
            tick_armed = 1'b0;
            add_sum = 1'b0;
            if (b != frame_sum) begin
              rx_phase = PH_WAIT;
              ev = EV_CSUM_BAD;
            end else begin
              // The checksum lands right after the payload if it fits.
              if (fill_ptr < BufferDepth) begin
                payload_mem[fill_ptr] = b;
                if (fill_ptr + 1 > mem_fill) mem_fill = fill_ptr + 1;
              end
              rx_phase = PH_HELD;
              ev = EV_OK;
            end
          end
          default: begin
            rx_phase = PH_WAIT;
            if (b != hdr_cfg) begin
              add_sum = 1'b0;
            end else begin
              rx_phase = PH_LEN;
              frame_sum = '0;
              tick_count = '0;
              tick_armed = 1'b1;
              ev = EV_HEADER;
            end
          end
        endcase
        if (add_sum) frame_sum = frame_sum + b;
      end
      OP_TICK: begin
        if (tick_armed) begin
          lim = (timeout_cfg == 16'd0) ? 16'd1 : timeout_cfg;
          if (tick_count < TickMax) tick_count++;
          if (tick_count >= lim) begin
            tick_armed = 1'b0;
            rx_phase = PH_WAIT;
            ev = EV_TIMEOUT;
          end
        end
      end
      OP_DISCARD: begin
        rx_phase = PH_WAIT;
        tick_armed = 1'b0;
      end
      default: begin
        r.read_data = payload_mem[it.read_index];
      end
    endcase
    r.packet_ready = (rx_phase == PH_HELD);
    r.packet_type = type_q;
    r.packet_address = addr_q;
    r.payload_length = len_q;
    r.event_res = ev;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Both channels are sampled here, at the clock edge, so the prediction
  // for an input transfer is queued before any result of the same edge is
  // compared against the queue.
  always @(posedge clk_i) begin
    spr_out_t want;
    spr_out_t got;
    pinned_t  pin;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        pin = pinned_q.pop_front();
        want = deframe_step(in_data);
        if (pin.typed) begin
          want.event_res = pin.ev;
          want.packet_ready = pin.ready;
        end
        pending_status_q.push_back(want);
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        got = out_data;
        ev_seen[got.event_res]++;
        if (pending_status_q.size() == 0) begin
          $display("%0t: status word 0x%0h arrived with nothing expected", $time, got);
          n_errors++;
        end else begin
          want = pending_status_q.pop_front();
          check_field("packet_ready", 8'(want.packet_ready), 8'(got.packet_ready));
          check_field("packet_type", want.packet_type, got.packet_type);
          check_field("packet_address", want.packet_address, got.packet_address);
          check_field("payload_length", want.payload_length, got.payload_length);
          check_field("read_data", want.read_data, got.read_data);
          check_field("event_res", 8'(want.event_res), 8'(got.event_res));
          n_matched++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Watchdog: the run is hung if nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver side back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Presents one item and returns once the monitor has taken its transfer.
  task automatic send_item(op_e op, logic [7:0] dbyte, logic [7:0] ridx, pinned_t pin);
    spr_in_t it;
    it.opcode = op;
    it.data_byte = dbyte;
    it.read_index = ridx;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    pinned_q.push_back(pin);
    in_valid <= 1'b1;
    in_data <= it;
    n_sent++;
    wait (n_accepted == n_sent);
  endtask

  // Holds the input off until every outstanding status word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (n_matched == n_sent);
  endtask

  // Registers change only with the block idle: the input is drained and
  // every status word has returned before the write is presented.
  task automatic write_reg(cfg_idx_e ri, logic [15:0] val);
    settle();
    repeat (3) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (ri == CFG_HEADER) begin
      hdr_cfg = val[7:0];
    end else begin
      timeout_cfg = val;
    end
    n_cfg_writes++;
  endtask

  // Reads only entries that have been written at least once.
  task automatic send_read();
    send_item(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(mem_fill - 1)), NoPin);
  endtask

  // Sends a frame for the current header value. Ticks may be mixed in
  // between bytes, and cut >= 0 stops the frame after that many bytes.
  task automatic send_frame(int plen, bit good, int tick_pct, int cut);
    logic [7:0] frame_q [$];
    logic [7:0] sum;
    int         n;
    frame_q.push_back(hdr_cfg);
    frame_q.push_back(8'(plen + LengthBias));
    repeat (plen + 2) frame_q.push_back(8'($urandom_range(255)));
    sum = '0;
    foreach (frame_q[i]) sum += frame_q[i];
    frame_q.push_back(good ? sum : 8'(sum + $urandom_range(1, 255)));
    n = (cut < 0) ? frame_q.size() : cut;
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(99) < tick_pct) begin
        send_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)), NoPin);
      end
      send_item(OP_BYTE, frame_q[i], 8'($urandom_range(255)), NoPin);
    end
  endtask

  initial begin
    int         phase_end;
    int         sel;
    int         post;
    int         n_ticks;
    logic [7:0] hdr;
    logic [15:0] tmo;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: register rows wait for an idle block first.
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        send_item(directed_steps[i].op, directed_steps[i].data, directed_steps[i].idx,
                  directed_steps[i].pin);
      end
    end
    n_directed = n_sent;

    // Random phases, each with its own header, timeout and pacing.
    for (int p = 0; p < 4; p++) begin
      hdr = (p == 1) ? 8'h00 : (p == 2) ? 8'hFF : 8'($urandom_range(255));
      tmo = (p == 1) ? 16'd1 : (p == 3) ? 16'hFFFF : 16'($urandom_range(2, 40));
      write_reg(CFG_HEADER, {8'h00, hdr});
      write_reg(CFG_TIMEOUT, tmo);
      src_idle_pct = src_pct_tbl[p];
      sink_stall_pct = sink_pct_tbl[p];

      // One full-size frame fills the whole buffer so that reads can reach
      // every index. The discard first puts the deframer back to waiting
      // for a header, whatever the table left behind.
      if (p == 0) begin
        send_item(OP_DISCARD, 8'($urandom_range(255)), 8'($urandom_range(255)), NoPin);
        send_frame(255, 1'b1, 0, -1);
        repeat (8) send_read();
        send_item(OP_DISCARD, 8'($urandom_range(255)), 8'($urandom_range(255)), NoPin);
      end

      phase_end = n_sent + 140;
      while (n_sent < phase_end) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          // Well-formed frame, mostly with a good checksum.
          send_frame($urandom_range(0, 12), ($urandom_range(99) < 85),
                     ($urandom_range(1) == 0) ? 0 : 15, -1);
          post = $urandom_range(99);
          if (post < 30) begin
            repeat ($urandom_range(1, 3)) send_read();
          end
          // Otherwise the held packet is left for the next byte to drop.
          if (post < 80) begin
            send_item(OP_DISCARD, 8'($urandom_range(255)), 8'($urandom_range(255)), NoPin);
          end
        end else if (sel < 82) begin
          // Frame cut after 1 to 5 bytes, then ticks (timing out only a short timeout) or a discard.
          send_frame($urandom_range(0, 12), 1'b1, 0, $urandom_range(1, 5));
          if ($urandom_range(1) == 0) begin
            n_ticks = (timeout_cfg > 16'd48) ? 8 : int'(timeout_cfg) + 1;
            repeat (n_ticks) begin
              send_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)), NoPin);
            end
          end else begin
            send_item(OP_DISCARD, 8'($urandom_range(255)), 8'($urandom_range(255)), NoPin);
          end
        end else begin
          // Loose item of any kind.
          case ($urandom_range(3))
            0: send_item(OP_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)), NoPin);
            1: send_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)), NoPin);
            2: send_item(OP_DISCARD, 8'($urandom_range(255)), 8'($urandom_range(255)), NoPin);
            default: send_read();
          endcase
        end
        if ($urandom_range(99) < 3) settle();
      end
    end

    // Drain, then keep the clock running so any stray result can still show.
    settle();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d items (%0d directed) under four pacing modes, %0d register writes.",
             n_sent, n_directed, n_cfg_writes);
    $display("Events: %0d headers, %0d good, %0d bad checksum, %0d timeouts, %0d drops.",
             ev_seen[EV_HEADER], ev_seen[EV_OK], ev_seen[EV_CSUM_BAD],
             ev_seen[EV_TIMEOUT], ev_seen[EV_DROPPED]);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
design/spr_pkg.sv
design/spr_store.sv
design/spr_ctrl.sv
design/serial_packet_receiver_top.sv
dv/tb_top.sv
